[design/pwm_ctrl_pkg.sv]
// Package for the PWM controller register block.
// Holds the bus word types, register offsets, size and op codes and bit constants.
// No dependencies.
`default_nettype none

package pwm_ctrl_pkg;

  // Aperture of the block in bytes
  localparam int unsigned APERTURE_BYTES = 16384;

  // Access direction codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Access size codes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  // Register offsets
  localparam logic [13:0] OFF_CR  = 14'h00;
  localparam logic [13:0] OFF_SR  = 14'h04;
  localparam logic [13:0] OFF_IR  = 14'h08;
  localparam logic [13:0] OFF_SAR = 14'h0C;
  localparam logic [13:0] OFF_PR  = 14'h10;
  localparam logic [13:0] OFF_CNR = 14'h14;

  // Register bits and values
  localparam int unsigned CR_EN_BIT    = 0;
  localparam int unsigned CR_SWR_BIT   = 3;
  localparam logic [31:0] CR_SWR       = 32'h0000_0008;
  localparam logic [31:0] SR_FIFO_FREE = 32'h0000_0004;
  localparam logic [31:0] PERIOD_RESET = 32'h0000_FFFF;
  localparam logic [31:0] BYTE_MASK    = 32'h0000_00FF;
  localparam logic [31:0] HALF_MASK    = 32'h0000_FFFF;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EXEC,
    ST_OUT
  } state_e;

  // Input word: one bus access
  typedef struct packed {
    logic        op;
    logic [13:0] offset;
    logic [1:0]  access_size;
    logic [31:0] write_data;
  } req_t;

  // Output word: read data and error flag
  typedef struct packed {
    logic [31:0] read_data;
    logic        access_error;
  } rsp_t;

endpackage

`default_nettype wire

[design/pwm_controller_register_block.sv]
// Top level of the PWM controller register block: bus decode, registers and counter.
// Uses pwm_ctrl_pkg for word types, offsets and codes.
// The block takes one bus access word at a time and returns one response word per access.
// Most accesses go from acceptance to a valid response through capture, execute and
// present. A read of the counter, or a byte or halfword write to it, while the enable
// bit is set first advances the counter modulo period+2 (a period of 0 counts as 1)
// through a bit-serial restoring remainder unit that takes 33 steps over the 33-bit
// dividend. The input side stalls from acceptance until the response word has been taken.
`default_nettype none

module pwm_controller_register_block (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_stall_o,
  input  wire pwm_ctrl_pkg::req_t in_data_i,
  output logic                  out_valid_o,
  input  wire                   out_stall_i,
  output pwm_ctrl_pkg::rsp_t    out_data_o
);

  pwm_ctrl_pkg::state_e state_q, state_d;

  // Registers
  logic [31:0] control_q, irq_en_q, sample_q, period_q, count_q;

  // Captured request and error flag
  pwm_ctrl_pkg::req_t req_q;
  logic               err_q;

  // Remainder unit
  logic [32:0] dvd_q, div_q, rem_q;
  logic [5:0]  step_q;
  logic [33:0] rem_sh, diff;
  logic        ge;
  logic [32:0] rem_d;

  // Response register
  pwm_ctrl_pkg::rsp_t rsp_q;

  // Accept-time decode
  logic        in_acc;
  logic [13:0] in_aligned;
  logic        in_decoded;
  logic        in_err;
  logic        in_adv;
  logic [31:0] per_eff;

  // Execute-time datapath
  logic [13:0] aligned;
  logic [1:0]  lane;
  logic [4:0]  sh;
  logic [31:0] word_rd;
  logic [31:0] base_mask;
  logic [31:0] mask;
  logic [31:0] merged;
  logic [31:0] wr_val;
  logic [31:0] rd_val;
  logic        do_write;

  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_aligned = {in_data_i.offset[13:2], 2'b00};

  // Decode the six word registers
  always_comb begin
    case (in_aligned)
      pwm_ctrl_pkg::OFF_CR, pwm_ctrl_pkg::OFF_SR, pwm_ctrl_pkg::OFF_IR,
      pwm_ctrl_pkg::OFF_SAR, pwm_ctrl_pkg::OFF_PR, pwm_ctrl_pkg::OFF_CNR:
        in_decoded = 1'b1;
      default: in_decoded = 1'b0;
    endcase
  end

  // Flag bad size, range, offset or word alignment
  assign in_err = !(in_data_i.access_size inside {pwm_ctrl_pkg::SIZE_BYTE,
                                                  pwm_ctrl_pkg::SIZE_HALF,
                                                  pwm_ctrl_pkg::SIZE_WORD}) ||
                  (32'(in_data_i.offset) >= pwm_ctrl_pkg::APERTURE_BYTES) ||
                  !in_decoded ||
                  ((in_data_i.access_size == pwm_ctrl_pkg::SIZE_WORD) &&
                   (in_data_i.offset[1:0] != 2'b00));

  // When enabled, the counter advances on any valid read of it and on a narrow write (read-modify-write)
  assign in_adv = !in_err && (in_aligned == pwm_ctrl_pkg::OFF_CNR) &&
                  control_q[pwm_ctrl_pkg::CR_EN_BIT] &&
                  ((in_data_i.op == pwm_ctrl_pkg::OP_READ) ||
                   (in_data_i.access_size != pwm_ctrl_pkg::SIZE_WORD));

  assign per_eff = (period_q == 32'd0) ? 32'd1 : period_q;

  // One restoring remainder step
  assign rem_sh = {rem_q, dvd_q[32]};
  assign diff   = rem_sh - {1'b0, div_q};
  assign ge     = rem_sh >= {1'b0, div_q};
  assign rem_d  = ge ? diff[32:0] : rem_sh[32:0];

  // Execute: read the aligned word and form the merged write value
  assign aligned   = {req_q.offset[13:2], 2'b00};
  assign lane      = req_q.offset[1:0];
  assign sh        = {lane, 3'b000};
  assign base_mask = (req_q.access_size == pwm_ctrl_pkg::SIZE_BYTE) ?
                     pwm_ctrl_pkg::BYTE_MASK : pwm_ctrl_pkg::HALF_MASK;
  assign mask      = base_mask << sh;
  assign merged    = (word_rd & ~mask) | (((req_q.write_data & base_mask) << sh) & mask);
  assign wr_val    = (req_q.access_size == pwm_ctrl_pkg::SIZE_WORD) ?
                     req_q.write_data : merged;
  assign do_write  = !err_q && (req_q.op == pwm_ctrl_pkg::OP_WRITE);

  always_comb begin
    case (aligned)
      pwm_ctrl_pkg::OFF_CR:  word_rd = control_q & ~pwm_ctrl_pkg::CR_SWR;
      pwm_ctrl_pkg::OFF_SR:  word_rd = pwm_ctrl_pkg::SR_FIFO_FREE;
      pwm_ctrl_pkg::OFF_IR:  word_rd = irq_en_q;
      pwm_ctrl_pkg::OFF_SAR: word_rd = sample_q;
      pwm_ctrl_pkg::OFF_PR:  word_rd = period_q;
      pwm_ctrl_pkg::OFF_CNR: word_rd = count_q;
      default:               word_rd = 32'd0;
    endcase
  end

  // Shift the read word down to the accessed lane
  always_comb begin
    case (req_q.access_size)
      pwm_ctrl_pkg::SIZE_BYTE: rd_val = (word_rd >> sh) & pwm_ctrl_pkg::BYTE_MASK;
      pwm_ctrl_pkg::SIZE_HALF: rd_val = (word_rd >> {lane[1], 4'b0000}) &
                                        pwm_ctrl_pkg::HALF_MASK;
      default:                 rd_val = word_rd;
    endcase
  end

  // Sequencer state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pwm_ctrl_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and handshake outputs
  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      pwm_ctrl_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = in_adv ? pwm_ctrl_pkg::ST_DIV : pwm_ctrl_pkg::ST_EXEC;
        end
      end
      pwm_ctrl_pkg::ST_DIV: begin
        if (step_q == 6'd0) begin
          state_d = pwm_ctrl_pkg::ST_EXEC;
        end
      end
      pwm_ctrl_pkg::ST_EXEC: begin
        state_d = pwm_ctrl_pkg::ST_OUT;
      end
      pwm_ctrl_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          state_d = pwm_ctrl_pkg::ST_IDLE;
        end
      end
      default: state_d = pwm_ctrl_pkg::ST_IDLE;
    endcase
  end

  // Register file and counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      control_q <= 32'd0;
      irq_en_q  <= 32'd0;
      sample_q  <= 32'd0;
      period_q  <= pwm_ctrl_pkg::PERIOD_RESET;
      count_q   <= 32'd0;
    end else begin
      // Store the remainder when the last step finishes
      if ((state_q == pwm_ctrl_pkg::ST_DIV) && (step_q == 6'd0)) begin
        count_q <= rem_d[31:0];
      end
      if ((state_q == pwm_ctrl_pkg::ST_EXEC) && do_write) begin
        case (aligned)
          pwm_ctrl_pkg::OFF_CR: begin
            control_q <= wr_val & ~pwm_ctrl_pkg::CR_SWR;
            if (wr_val[pwm_ctrl_pkg::CR_SWR_BIT]) begin
              sample_q <= 32'd0;
              count_q  <= 32'd0;
            end
          end
          pwm_ctrl_pkg::OFF_IR:  irq_en_q <= wr_val;
          pwm_ctrl_pkg::OFF_SAR: sample_q <= wr_val;
          pwm_ctrl_pkg::OFF_PR:  period_q <= wr_val;
          pwm_ctrl_pkg::OFF_CNR: count_q  <= wr_val;
          default: ;
        endcase
      end
    end
  end

  // Capture the request and run the remainder unit
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q  <= in_data_i;
      err_q  <= in_err;
      dvd_q  <= {1'b0, count_q} + 33'd1;
      div_q  <= {1'b0, per_eff} + 33'd2;
      rem_q  <= 33'd0;
      step_q <= 6'd32;
    end else if (state_q == pwm_ctrl_pkg::ST_DIV) begin
      rem_q  <= rem_d;
      dvd_q  <= {dvd_q[31:0], 1'b0};
      step_q <= step_q - 6'd1;
    end
  end

  // Response register: hold while waiting to be taken
  always_ff @(posedge clk_i) begin
    if (state_q == pwm_ctrl_pkg::ST_EXEC) begin
      rsp_q.access_error <= err_q;
      rsp_q.read_data    <= (!err_q && (req_q.op == pwm_ctrl_pkg::OP_READ)) ?
                            rd_val : 32'd0;
    end
  end

  assign out_data_o = rsp_q;

endmodule

`default_nettype wire
